// File: src/fpf_pkg.sv
// Shared types, constants and the CRC step function for the page packet framer.
package fpf_pkg;

    localparam int WORDS_PER_PAGE = 256;
    localparam int WORD_CNT_W     = $clog2(WORDS_PER_PAGE + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_CMD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_SUB  = 1'd1;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_WORD  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  page_number;
        logic [31:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_WORD,
        OP_WORD_LAST
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [7:0]  page;
        logic [31:0] data;
    } cmd_t;

    typedef struct packed {
        logic [7:0] write_cmd;
        logic [7:0] data_sub;
    } hdr_t;

    // Feed one byte into the reflected CRC, bit 7 first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data_in);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int k = 7; k >= 0; k--) begin
            fb = c[0] ^ data_in[k];
            c  = {1'b0, c[15:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// File: src/flash_page_packet_framer_crc16.sv
// Top level of the flash page packet framer with reflected CRC-16.
//
// Usage:
//   s_valid/s_ready/s_item carry requests: kind 0 opens a page and emits the
//   write command byte, the data write subcommand byte and the page byte;
//   kind 1 carries one image word, emitted most significant byte first.
//   After WORDS_PER_PAGE words the CRC high and low bytes follow, last set
//   on the low byte. Words with no page open are dropped.
//   m_valid/m_ready/m_item deliver the packet bytes, one byte per output handshake.
//   cfg_we/cfg_index/cfg_data write the two header bytes; write only while idle.
// Path: an accepted request is first written into the queue, and its first
//   byte is then loaded into the output register that drives m_item.
// Throughput: one output byte per cycle while m_ready is high and the queue
//   is not empty; a start request yields 3 bytes, a data word 4, the closing
//   word of a page 6, all through the single byte-wide output register.
// Reset (aresetn low, synchronous): no page open, queue empty, output idle,
//   header bytes zero.
// Stall: while m_ready is low the output byte holds; the 4-entry command
//   queue keeps taking requests until it fills, then s_ready drops.
module flash_page_packet_framer_crc16
    import fpf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    hdr_t hdr_reg, hdr_next;
    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_push_cmd, q_head_cmd;

    // Header byte registers; index decode picks the byte to update.
    always_comb begin
        hdr_next = hdr_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_WRITE_CMD: hdr_next.write_cmd = cfg_data;
                CFG_DATA_SUB:  hdr_next.data_sub  = cfg_data;
                default:       hdr_next = hdr_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg <= '0;
        end else begin
            hdr_reg <= hdr_next;
        end
    end

    // Classify requests and track page progress.
    fpf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_push  (q_push),
        .q_cmd   (q_push_cmd),
        .q_full  (q_full)
    );

    // Decouple request intake from byte output.
    fpf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (q_head_cmd),
        .empty    (q_empty)
    );

    // Emit bytes, advancing the CRC one byte per cycle on page and data bytes that move out.
    fpf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .hdr      (hdr_reg),
        .head_cmd (q_head_cmd),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

// File: src/fpf_front.sv
// Front end: accepts requests, tracks the open page and queues byte commands.
module fpf_front
    import fpf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     q_push,
    output cmd_t     q_cmd,
    input  logic     q_full
);

    logic                  page_open_reg, page_open_next;
    logic [WORD_CNT_W-1:0] words_done_reg, words_done_next;
    logic                  accept;
    logic [WORD_CNT_W-1:0] words_inc;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign words_inc = words_done_reg + WORD_CNT_W'(1);

    always_comb begin
        page_open_next  = page_open_reg;
        words_done_next = words_done_reg;
        q_push          = 1'b0;
        q_cmd.op        = OP_START;
        q_cmd.page      = s_item.page_number;
        q_cmd.data      = s_item.data_word;
        if (accept) begin
            unique case (s_item.kind)
                KIND_START: begin
                    q_push          = 1'b1;
                    q_cmd.op        = OP_START;
                    page_open_next  = 1'b1;
                    words_done_next = '0;
                end
                default: begin
                    // drop words that arrive with no page open
                    if (page_open_reg) begin
                        q_push = 1'b1;
                        if (words_inc == WORD_CNT_W'(WORDS_PER_PAGE)) begin
                            q_cmd.op        = OP_WORD_LAST;
                            page_open_next  = 1'b0;
                            words_done_next = '0;
                        end else begin
                            q_cmd.op        = OP_WORD;
                            words_done_next = words_inc;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_open_reg  <= 1'b0;
            words_done_reg <= '0;
        end else begin
            page_open_reg  <= page_open_next;
            words_done_reg <= words_done_next;
        end
    end

endmodule

// File: src/fpf_queue.sv
// Short command queue between the front end and the byte sequencer.
module fpf_queue
    import fpf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty
);

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/fpf_back.sv
// Back end: walks each queued command byte by byte, runs the CRC, drives the output.
module fpf_back
    import fpf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  hdr_t      hdr,
    input  cmd_t      head_cmd,
    input  logic      q_empty,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_item_reg, m_item_next;
    logic        adv;
    logic [2:0]  last_idx;
    logic [7:0]  cur_byte;
    logic        cur_last;
    logic [7:0]  data_byte;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
    assign adv     = !q_empty && (!m_valid_reg || m_ready);
    assign q_pop   = adv && (idx_reg == last_idx);

    always_comb begin
        case (idx_reg[1:0])
            2'd0:    data_byte = head_cmd.data[31:24];
            2'd1:    data_byte = head_cmd.data[23:16];
            2'd2:    data_byte = head_cmd.data[15:8];
            default: data_byte = head_cmd.data[7:0];
        endcase
    end

    always_comb begin
        cur_last = 1'b0;
        crc_next = crc_reg;
        unique case (head_cmd.op)
            OP_START: begin
                last_idx = 3'd2;
                unique case (idx_reg)
                    3'd0:    cur_byte = hdr.write_cmd;
                    3'd1:    cur_byte = hdr.data_sub;
                    default: cur_byte = head_cmd.page;
                endcase
                if (idx_reg == 3'd2) begin
                    crc_next = crc_feed(CRC_INIT, head_cmd.page);
                end
            end
            OP_WORD_LAST: begin
                last_idx = 3'd5;
                if (idx_reg == 3'd4) begin
                    cur_byte = crc_reg[15:8];
                end else if (idx_reg == 3'd5) begin
                    cur_byte = crc_reg[7:0];
                    cur_last = 1'b1;
                end else begin
                    cur_byte = data_byte;
                    crc_next = crc_feed(crc_reg, data_byte);
                end
            end
            default: begin
                last_idx = 3'd3;
                cur_byte = data_byte;
                crc_next = crc_feed(crc_reg, data_byte);
            end
        endcase
    end

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (adv) begin
            m_valid_next            = 1'b1;
            m_item_next.packet_byte = cur_byte;
            m_item_next.last        = cur_last;
            idx_next = (idx_reg == last_idx) ? 3'd0 : idx_reg + 3'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
        if (!aresetn) begin
            idx_reg     <= '0;
            crc_reg     <= CRC_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (adv) begin
                crc_reg <= crc_next;
            end
        end
    end

endmodule
